[src/iwd_pkg.sv]
// Shared constants, queue entry type and mixing helpers for the indexed word digest.
package iwd_pkg;

  localparam logic [63:0] MIX_M1   = 64'hBF58476D1CE4E5B9;
  localparam logic [63:0] MIX_M2   = 64'h94D049BB133111EB;
  localparam logic [63:0] LOW_MUL  = 64'h3C79AC492BA7B653;
  localparam logic [63:0] LOW_ADD  = 64'h1C69B3F74AC4AE35;
  localparam logic [63:0] HIGH_MUL = 64'h9E3779B185EBCA87;
  localparam logic [63:0] HIGH_ADD = 64'hD1B54A32D192ED03;
  localparam logic [63:0] FIN_LOW  = 64'hA0761D6478BD642F;
  localparam logic [63:0] FIN_HIGH = 64'hE7037ED1A0B428DB;

  // One keyed word handed from the front end to the back end.
  typedef struct packed {
    logic [63:0] key;
    logic [63:0] pos_rot;
  } q_entry_t;

  function automatic logic [63:0] mix_pre(input logic [63:0] x);
    return x ^ (x >> 30);
  endfunction

  function automatic logic [63:0] mix_mid(input logic [63:0] x);
    return x ^ (x >> 27);
  endfunction

  function automatic logic [63:0] mix_post(input logic [63:0] x);
    return x ^ (x >> 31);
  endfunction

  function automatic logic [63:0] rotl17(input logic [63:0] x);
    return {x[46:0], x[63:47]};
  endfunction

  function automatic logic [63:0] rotl27(input logic [63:0] x);
    return {x[36:0], x[63:37]};
  endfunction

  function automatic logic [63:0] rotl31(input logic [63:0] x);
    return {x[32:0], x[63:33]};
  endfunction

  function automatic logic [63:0] rotl32(input logic [63:0] x);
    return {x[31:0], x[63:32]};
  endfunction

endpackage

[src/indexed_word_digest_128.sv]
// Top level of the indexed word digest: front end, key queue and back end.
// Each transfer on the input carries a 32-bit word and its 64-bit position; each one
// yields exactly one result holding the finalised 128-bit digest and the running
// word count (wrapping at 2^64), in input order. The front end builds the word's key
// and queues it; the input stalls from each transfer until that key is queued.
// The back end works on one word at a time with its single shared 32x32 multiplier,
// which forms the six 64-bit products of the two lane updates and the two finalising
// mixes, after it takes the key and before it loads the result. The front end can
// build the next key while the back end is still busy with the previous word.
// A finished result waits in the output register while the next word is already being
// worked on.
module indexed_word_digest_128 #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_word,
  input  logic [63:0] in_position,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_digest_low,
  output logic [63:0] out_digest_high,
  output logic [63:0] out_words_absorbed
);
  import iwd_pkg::*;

  logic     q_wr;
  logic     q_rd;
  logic     q_full;
  logic     q_empty;
  q_entry_t q_wdata;
  q_entry_t q_rdata;

  iwd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_word     (in_word),
    .in_position (in_position),
    .q_wr        (q_wr),
    .q_wdata     (q_wdata),
    .q_full      (q_full)
  );

  iwd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .rdata (q_rdata),
    .empty (q_empty)
  );

  iwd_back u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_rdata            (q_rdata),
    .q_rd               (q_rd),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_digest_low     (out_digest_low),
    .out_digest_high    (out_digest_high),
    .out_words_absorbed (out_words_absorbed)
  );

endmodule

[src/iwd_mul64.sv]
// Multi-cycle 64x64 multiplier giving the low 64 product bits from one 32x32 multiplier.
module iwd_mul64 (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic        done,
  output logic [63:0] p
);

  typedef enum logic [2:0] {
    M_IDLE,
    M_LL,
    M_LH,
    M_HL,
    M_SUM
  } mstate_t;

  mstate_t     state_r, state_nxt;
  logic [63:0] a_r, a_nxt;
  logic [63:0] b_r, b_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic        done_r, done_nxt;
  logic [31:0] mul_x;
  logic [31:0] mul_y;
  logic [63:0] mul_p;

  always_comb begin
    case (state_r)
      M_LH: begin
        mul_x = a_r[31:0];
        mul_y = b_r[63:32];
      end
      M_HL: begin
        mul_x = a_r[63:32];
        mul_y = b_r[31:0];
      end
      default: begin
        mul_x = a_r[31:0];
        mul_y = b_r[31:0];
      end
    endcase
  end

  assign mul_p = {32'h0, mul_x} * {32'h0, mul_y};

  // Cross terms only reach the upper half, so their low 32 bits suffice.
  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    prod_nxt  = prod_r;
    acc_nxt   = acc_r;
    done_nxt  = 1'b0;
    case (state_r)
      M_IDLE: begin
        if (start) begin
          a_nxt     = a;
          b_nxt     = b;
          state_nxt = M_LL;
        end
      end
      M_LL: begin
        prod_nxt  = mul_p;
        state_nxt = M_LH;
      end
      M_LH: begin
        acc_nxt   = prod_r;
        prod_nxt  = mul_p;
        state_nxt = M_HL;
      end
      M_HL: begin
        acc_nxt   = acc_r + {prod_r[31:0], 32'h0};
        prod_nxt  = mul_p;
        state_nxt = M_SUM;
      end
      M_SUM: begin
        acc_nxt   = acc_r + {prod_r[31:0], 32'h0};
        done_nxt  = 1'b1;
        state_nxt = M_IDLE;
      end
      default: state_nxt = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    if (!rst_n) begin
      state_r <= M_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  assign done = done_r;
  assign p    = acc_r;

endmodule

[src/iwd_front.sv]
// Front end: accepts words and derives the per-word key from word, position and count.
module iwd_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [31:0]       in_word,
  input  logic [63:0]       in_position,
  output logic              q_wr,
  output iwd_pkg::q_entry_t q_wdata,
  input  logic              q_full
);
  import iwd_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_M1_GO,
    S_M1_WAIT,
    S_M2_GO,
    S_M2_WAIT,
    S_PUSH
  } fstate_t;

  fstate_t     state_r, state_nxt;
  logic [63:0] count_r, count_nxt;
  logic [63:0] x_r, x_nxt;
  logic [63:0] prot_r, prot_nxt;
  logic        mul_start;
  logic [63:0] mul_b;
  logic        mul_done;
  logic [63:0] mul_p;

  assign mul_start = (state_r == S_M1_GO) || (state_r == S_M2_GO);
  assign mul_b     = (state_r == S_M2_GO) ? MIX_M2 : MIX_M1;

  iwd_mul64 u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (x_r),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  // The key uses the count before this word.
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    x_nxt     = x_r;
    prot_nxt  = prot_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          x_nxt     = mix_pre(in_position ^ {in_word, 32'h0} ^ count_r);
          prot_nxt  = rotl17(in_position);
          count_nxt = count_r + 64'd1;
          state_nxt = S_M1_GO;
        end
      end
      S_M1_GO:   state_nxt = S_M1_WAIT;
      S_M1_WAIT: begin
        if (mul_done) begin
          x_nxt     = mix_mid(mul_p);
          state_nxt = S_M2_GO;
        end
      end
      S_M2_GO:   state_nxt = S_M2_WAIT;
      S_M2_WAIT: begin
        if (mul_done) begin
          x_nxt     = mix_post(mul_p);
          state_nxt = S_PUSH;
        end
      end
      S_PUSH: begin
        if (!q_full) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    x_r    <= x_nxt;
    prot_r <= prot_nxt;
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  assign in_stall        = (state_r != S_IDLE);
  assign q_wr            = (state_r == S_PUSH) && !q_full;
  assign q_wdata.key     = x_r;
  assign q_wdata.pos_rot = prot_r;

endmodule

[src/iwd_queue.sv]
// Small register FIFO carrying keyed words from the front end to the back end.
module iwd_queue #(
  parameter int DEPTH = 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr,
  input  iwd_pkg::q_entry_t wdata,
  output logic              full,
  input  logic              rd,
  output iwd_pkg::q_entry_t rdata,
  output logic              empty
);
  import iwd_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  q_entry_t        mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   fill_r, fill_nxt;

  assign full  = (fill_r == CW'(DEPTH));
  assign empty = (fill_r == '0);
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (wr) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (rd) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (wr && !rd) begin
      fill_nxt = fill_r + CW'(1);
    end else if (rd && !wr) begin
      fill_nxt = fill_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wr_ptr_r] <= wdata;
    end
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n) full |-> !wr)
    else $error("queue written while full");
  a_no_read_empty: assert property (@(posedge clk) disable iff (!rst_n) empty |-> !rd)
    else $error("queue read while empty");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
      fill_r <= CW'(DEPTH))
    else $error("queue fill count beyond depth");
  a_fill_track: assert property (@(posedge clk) disable iff (!rst_n)
      (wr && !rd) |=> (fill_r == $past(fill_r) + CW'(1)))
    else $error("queue fill count lost a transfer");
`endif

endmodule

[src/iwd_back.sv]
// Back end: updates both lanes with each key, finalises the digest and holds the result.
module iwd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  iwd_pkg::q_entry_t q_rdata,
  output logic              q_rd,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [63:0]       out_digest_low,
  output logic [63:0]       out_digest_high,
  output logic [63:0]       out_words_absorbed
);
  import iwd_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LL_GO,
    S_LL_WAIT,
    S_LH_GO,
    S_LH_WAIT,
    S_MIXA_GO,
    S_MIXA_WAIT,
    S_MIXB_GO,
    S_MIXB_WAIT,
    S_OUT
  } bstate_t;

  bstate_t     state_r, state_nxt;
  logic [63:0] lane_low_r, lane_low_nxt;
  logic [63:0] lane_high_r, lane_high_nxt;
  logic [63:0] count_r, count_nxt;
  logic [63:0] t_r, t_nxt;
  logic [63:0] h_r, h_nxt;
  logic [63:0] x_r, x_nxt;
  logic [63:0] dl_r, dl_nxt;
  logic        sel_hi_r, sel_hi_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [63:0] out_dl_r, out_dl_nxt;
  logic [63:0] out_dh_r, out_dh_nxt;
  logic [63:0] out_cnt_r, out_cnt_nxt;
  logic        mul_start;
  logic [63:0] mul_a;
  logic [63:0] mul_b;
  logic        mul_done;
  logic [63:0] mul_p;
  logic [63:0] mix_res;

  always_comb begin
    mul_start = 1'b0;
    mul_a     = x_r;
    mul_b     = MIX_M1;
    case (state_r)
      S_LL_GO: begin
        mul_start = 1'b1;
        mul_a     = t_r;
        mul_b     = LOW_MUL;
      end
      S_LH_GO: begin
        mul_start = 1'b1;
        mul_a     = h_r;
        mul_b     = HIGH_MUL;
      end
      S_MIXA_GO: begin
        mul_start = 1'b1;
      end
      S_MIXB_GO: begin
        mul_start = 1'b1;
        mul_b     = MIX_M2;
      end
      default: mul_start = 1'b0;
    endcase
  end

  iwd_mul64 u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  assign mix_res = mix_post(mul_p);
  assign q_rd    = (state_r == S_IDLE) && !q_empty;

  always_comb begin
    state_nxt     = state_r;
    lane_low_nxt  = lane_low_r;
    lane_high_nxt = lane_high_r;
    count_nxt     = count_r;
    t_nxt         = t_r;
    h_nxt         = h_r;
    x_nxt         = x_r;
    dl_nxt        = dl_r;
    sel_hi_nxt    = sel_hi_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_dl_nxt    = out_dl_r;
    out_dh_nxt    = out_dh_r;
    out_cnt_nxt   = out_cnt_r;
    case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          t_nxt     = rotl27(lane_low_r ^ q_rdata.key);
          h_nxt     = rotl31(lane_high_r + (q_rdata.key ^ q_rdata.pos_rot));
          count_nxt = count_r + 64'd1;
          state_nxt = S_LL_GO;
        end
      end
      S_LL_GO:   state_nxt = S_LL_WAIT;
      S_LL_WAIT: begin
        if (mul_done) begin
          lane_low_nxt = mul_p + LOW_ADD;
          state_nxt    = S_LH_GO;
        end
      end
      S_LH_GO:   state_nxt = S_LH_WAIT;
      S_LH_WAIT: begin
        if (mul_done) begin
          lane_high_nxt = mul_p + HIGH_ADD;
          x_nxt         = mix_pre(lane_low_r ^ count_r ^ FIN_LOW);
          sel_hi_nxt    = 1'b0;
          state_nxt     = S_MIXA_GO;
        end
      end
      S_MIXA_GO:   state_nxt = S_MIXA_WAIT;
      S_MIXA_WAIT: begin
        if (mul_done) begin
          x_nxt     = mix_mid(mul_p);
          state_nxt = S_MIXB_GO;
        end
      end
      S_MIXB_GO:   state_nxt = S_MIXB_WAIT;
      S_MIXB_WAIT: begin
        if (mul_done) begin
          if (!sel_hi_r) begin
            // Low half done; the high half folds it in.
            dl_nxt     = mix_res;
            x_nxt      = mix_pre(lane_high_r ^ rotl32(count_r) ^ mix_res ^ FIN_HIGH);
            sel_hi_nxt = 1'b1;
            state_nxt  = S_MIXA_GO;
          end else begin
            x_nxt     = mix_res;
            state_nxt = S_OUT;
          end
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_dl_nxt    = dl_r;
          out_dh_nxt    = x_r;
          out_cnt_nxt   = count_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    t_r       <= t_nxt;
    h_r       <= h_nxt;
    x_r       <= x_nxt;
    dl_r      <= dl_nxt;
    sel_hi_r  <= sel_hi_nxt;
    out_dl_r  <= out_dl_nxt;
    out_dh_r  <= out_dh_nxt;
    out_cnt_r <= out_cnt_nxt;
    if (!rst_n) begin
      state_r     <= S_IDLE;
      lane_low_r  <= '0;
      lane_high_r <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      lane_low_r  <= lane_low_nxt;
      lane_high_r <= lane_high_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_digest_low     = out_dl_r;
  assign out_digest_high    = out_dh_r;
  assign out_words_absorbed = out_cnt_r;

endmodule

[bench/testbench.sv]
// Self-checking testbench for the indexed word digest: directed and random word streams.
module testbench;
  import iwd_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 60;

  typedef struct {
    logic [63:0] digest_low;
    logic [63:0] digest_high;
    logic [63:0] words_absorbed;
  } digest_result_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] in_word;
  logic [63:0] in_position;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [63:0] out_digest_low;
  logic [63:0] out_digest_high;
  logic [63:0] out_words_absorbed;

  // running digest state, mirrors the block
  logic [63:0] lane_lo = '0;
  logic [63:0] lane_hi = '0;
  logic [63:0] absorbed_count = '0;

  digest_result_t pending_digests[$];
  int mismatch_count = 0;
  int idle_cycles = 0;
  int stall_left = 0;
  bit gaps_enabled = 1'b0;
  bit stall_enabled = 1'b0;

  indexed_word_digest_128 dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_word           (in_word),
    .in_position       (in_position),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_digest_low    (out_digest_low),
    .out_digest_high   (out_digest_high),
    .out_words_absorbed(out_words_absorbed)
  );

  always #5 clk = ~clk;

  function automatic logic [63:0] rotl64(input logic [63:0] x, input int unsigned k);
    return (x << k) | (x >> (64 - k));
  endfunction

  function automatic logic [63:0] avalanche64(input logic [63:0] x);
    logic [63:0] v;
    v = x ^ (x >> 30);
    v = v * MIX_M1;
    v = v ^ (v >> 27);
    v = v * MIX_M2;
    return v ^ (v >> 31);
  endfunction

  // Absorbs one word into the mirrored lanes and returns the digest that follows.
  function automatic digest_result_t absorb_word(input logic [31:0] w, input logic [63:0] p);
    logic [63:0] key;
    logic [63:0] dl;
    logic [63:0] dh;
    key = avalanche64(p ^ {w, 32'h0} ^ absorbed_count);
    lane_lo = rotl64(lane_lo ^ key, 27) * LOW_MUL + LOW_ADD;
    lane_hi = rotl64(lane_hi + (key ^ rotl64(p, 17)), 31) * HIGH_MUL + HIGH_ADD;
    absorbed_count = absorbed_count + 64'd1;
    dl = avalanche64(lane_lo ^ absorbed_count ^ FIN_LOW);
    dh = avalanche64(lane_hi ^ rotl64(absorbed_count, 32) ^ dl ^ FIN_HIGH);
    return '{dl, dh, absorbed_count};
  endfunction

  // mostly short, now and then long
  function automatic int pick_pause();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(20, 60);
  endfunction

  task automatic note_mismatch(input string what, input logic [63:0] want,
                               input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch %s: expected %h, got %h", what, want, got);
  endtask

  task automatic check_field(input string what, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) note_mismatch(what, want, got);
  endtask

  // Called at a rising edge; returns at the edge of the transfer or after the gap.
  task automatic send_word(input logic [31:0] w, input logic [63:0] p);
    int gap;
    digest_result_t exp_d;
    in_valid <= 1'b1;
    in_word <= w;
    in_position <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    exp_d = absorb_word(w, p);
    pending_digests.insert(pending_digests.size(), exp_d);
    gap = gaps_enabled ? pick_pause() : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic test_field_extremes();
    gaps_enabled = 1'b1;
    stall_enabled = 1'b1;
    send_word(32'h0, 64'h0);
    send_word(32'hFFFF_FFFF, '1);
    send_word(32'h0, '1);
    send_word(32'hFFFF_FFFF, 64'h0);
    send_word(32'h5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    send_word(32'hAAAA_AAAA, 64'h5555_5555_5555_5555);
    send_word(32'h8000_0000, 64'h8000_0000_0000_0000);
    send_word(32'h0000_0001, 64'h1);
  endtask

  // repeated, descending and wrapping positions are all legal
  task automatic test_position_order();
    send_word(32'h1234_5678, 64'd7);
    send_word(32'h1234_5678, 64'd7);
    send_word(32'hDEAD_BEEF, 64'd7);
    send_word(32'h0BAD_F00D, 64'd3);
    send_word(32'hCAFE_0001, 64'hFFFF_FFFF_FFFF_FFFE);
    send_word(32'hCAFE_0002, '1);
    send_word(32'hCAFE_0003, 64'h0);
    send_word(32'hCAFE_0004, 64'h1);
  endtask

  // no gaps and no back-pressure
  task automatic test_back_to_back();
    gaps_enabled = 1'b0;
    stall_enabled = 1'b0;
    for (int i = 0; i < 8; i++)
      send_word($urandom, 64'h1000 + i);
  endtask

  task automatic test_random_stream(input int n_items);
    int sent;
    int run_len;
    int r;
    logic [63:0] base;
    logic [31:0] w;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(0, 99);
      // switch idling on and off so there are quiet stretches too
      if ($urandom_range(0, 9) == 0) begin
        gaps_enabled = $urandom_range(0, 3) != 0;
        stall_enabled = $urandom_range(0, 3) != 0;
      end
      run_len = (r < 80) ? $urandom_range(1, 16) : $urandom_range(1, 4);
      base = {$urandom, $urandom};
      if ($urandom_range(0, 9) == 0) base = '1 - $urandom_range(0, 5);
      if ($urandom_range(0, 9) == 0) base = 64'($urandom_range(0, 5));
      for (int i = 0; i < run_len; i++) begin
        case ($urandom_range(0, 19))
          0:       w = 32'h0;
          1:       w = 32'hFFFF_FFFF;
          default: w = $urandom;
        endcase
        if (r < 80) send_word(w, base + i);
        else if (r < 90) send_word(w, base);
        else send_word(w, {$urandom, $urandom});
        sent++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!stall_enabled) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      stall_left <= pick_pause();
    end
  end

  always @(posedge clk) begin : result_check
    digest_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_digests.size() == 0) begin
        note_mismatch("unexpected result, digest_low", 64'h0, out_digest_low);
      end else begin
        want = pending_digests.pop_front();
        check_field("digest_low", want.digest_low, out_digest_low);
        check_field("digest_high", want.digest_high, out_digest_high);
        check_field("words_absorbed", want.words_absorbed, out_words_absorbed);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_word = '0;
    in_position = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_field_extremes();
    test_position_order();
    test_back_to_back();
    test_random_stream(580);

    in_valid <= 1'b0;
    while (pending_digests.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
